/* src/ivm_pkg.sv */
// Shared types and constants for the interval value map.
`timescale 1ns / 1ps

package ivm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam logic signed [15:0] NO_DEST_VALUE = -16'sd1;

    typedef enum logic [0:0] {
        OP_ASSIGN = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ORDER = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Control from the sequencer to the table memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage

/* src/ivm_mem.sv */
// Breakpoint table memory with two banks, one read port and one write port.
`timescale 1ns / 1ps

module ivm_mem import ivm_pkg::*; #(
    parameter int ADDR_W = 7
) (
    input  logic                     aclk,
    input  mem_ctrl_t                ctrl,
    input  logic [ADDR_W-1:0]        rd_addr,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [63:0]       wr_time,
    input  logic signed [15:0]       wr_value,
    output logic signed [63:0]       rd_time,
    output logic signed [15:0]       rd_value
);

    logic [79:0] mem [2**ADDR_W];
    logic [79:0] rd_reg;

    // Registered read and single write per cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= {wr_time, wr_value};
        end
        if (ctrl.rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_time  = rd_reg[79:16];
    assign rd_value = rd_reg[15:0];

endmodule

/* src/ivm_seq.sv */
// Sequencer that streams the old table, splices in a region and merges neighbors, or looks up a value for a query.
`timescale 1ns / 1ps

module ivm_seq import ivm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic signed [63:0]    s_start_time,
    input  logic signed [63:0]    s_stop_time,
    input  logic signed [15:0]    s_region_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_found_value,
    output logic [CNT_W-1:0]      m_breakpoint_count,
    output logic [1:0]            m_status,
    output mem_ctrl_t             mem_ctrl,
    output logic [IDX_W:0]        rd_addr,
    output logic [IDX_W:0]        wr_addr,
    output logic signed [63:0]    wr_time,
    output logic signed [15:0]    wr_value,
    input  logic signed [63:0]    rd_time,
    input  logic signed [15:0]    rd_value
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_PROC  = 7'b0000100,
        ST_START = 7'b0001000,
        ST_STOP  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_SKIP = 2'd1,
        PH_POST = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] out_reg, out_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic bank_reg, bank_next;
    logic ovf_reg, ovf_next;
    logic signed [15:0] prev_reg, prev_next;
    logic signed [15:0] lstop_reg, lstop_next;
    logic signed [15:0] lstart_reg, lstart_next;
    logic op_reg;
    logic signed [63:0] start_reg, stop_reg;
    logic signed [15:0] value_reg;
    logic m_valid_reg, m_valid_next;
    logic signed [15:0] found_reg, found_next;
    logic [1:0] status_reg, status_next;

    logic emit_en;
    logic signed [63:0] emit_time;
    logic signed [15:0] emit_value;
    logic emit_do;
    logic le_start, lt_start, le_stop, commit;

    // Comparators on the fetched breakpoint time.
    assign lt_start = rd_time < start_reg;
    assign le_start = rd_time <= start_reg;
    assign le_stop  = rd_time <= stop_reg;
    assign emit_do  = emit_en && (emit_value != prev_reg);
    assign commit   = (op_t'(op_reg) == OP_ASSIGN) && (start_reg < stop_reg) && !ovf_reg;

    assign rd_addr  = {bank_reg, idx_reg[IDX_W-1:0]};
    assign wr_addr  = {~bank_reg, out_reg[IDX_W-1:0]};
    assign wr_time  = emit_time;
    assign wr_value = emit_value;

    // Next-state logic of the merge sequencer.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        out_next     = out_reg;
        count_next   = count_reg;
        bank_next    = bank_reg;
        ovf_next     = ovf_reg;
        prev_next    = prev_reg;
        lstop_next   = lstop_reg;
        lstart_next  = lstart_reg;
        m_valid_next = m_valid_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        emit_en      = 1'b0;
        emit_time    = start_reg;
        emit_value   = value_reg;
        mem_ctrl     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_READ;
                    phase_next  = PH_PRE;
                    idx_next    = '0;
                    out_next    = '0;
                    ovf_next    = 1'b0;
                    prev_next   = NO_DEST_VALUE;
                    lstop_next  = NO_DEST_VALUE;
                    lstart_next = NO_DEST_VALUE;
                end
            end
            ST_READ: begin
                if (idx_reg == count_reg) begin
                    unique case (phase_reg)
                        PH_PRE:  state_next = ST_START;
                        PH_SKIP: state_next = ST_STOP;
                        default: state_next = ST_DONE;
                    endcase
                end else begin
                    mem_ctrl.rd_en = 1'b1;
                    state_next     = ST_PROC;
                end
            end
            ST_PROC: begin
                if (le_start) begin
                    lstart_next = rd_value;
                end
                if (le_stop) begin
                    lstop_next = rd_value;
                end
                state_next = ST_READ;
                case (phase_reg)
                    PH_PRE: begin
                        if (lt_start) begin
                            emit_en    = 1'b1;
                            emit_time  = rd_time;
                            emit_value = rd_value;
                            idx_next   = idx_reg + 1'b1;
                        end else begin
                            state_next = ST_START;
                        end
                    end
                    PH_SKIP: begin
                        if (le_stop) begin
                            idx_next = idx_reg + 1'b1;
                        end else begin
                            state_next = ST_STOP;
                        end
                    end
                    default: begin
                        emit_en    = 1'b1;
                        emit_time  = rd_time;
                        emit_value = rd_value;
                        idx_next   = idx_reg + 1'b1;
                    end
                endcase
            end
            ST_START: begin
                emit_en    = 1'b1;
                emit_time  = start_reg;
                emit_value = value_reg;
                phase_next = PH_SKIP;
                state_next = ST_READ;
            end
            ST_STOP: begin
                emit_en    = 1'b1;
                emit_time  = stop_reg;
                emit_value = lstop_reg;
                phase_next = PH_POST;
                state_next = ST_READ;
            end
            ST_DONE: begin
                if (commit) begin
                    bank_next  = ~bank_reg;
                    count_next = out_reg;
                    found_next = value_reg;
                end else begin
                    found_next = lstart_reg;
                end
                if (op_t'(op_reg) == OP_ASSIGN && start_reg > stop_reg) begin
                    status_next = STATUS_ORDER;
                end else if (op_t'(op_reg) == OP_ASSIGN && start_reg < stop_reg && ovf_reg) begin
                    status_next = STATUS_FULL;
                end else begin
                    status_next = STATUS_OK;
                end
                m_valid_next = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // Merge stage: drop a word whose value equals its predecessor; flag overflow when the output table is full.
        if (emit_do) begin
            prev_next = emit_value;
            if (out_reg == CAP_C) begin
                ovf_next = 1'b1;
            end else begin
                mem_ctrl.wr_en = 1'b1;
                out_next       = out_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            bank_reg    <= bank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Work registers and the captured input word.
    always_ff @(posedge aclk) begin
        phase_reg  <= phase_next;
        idx_reg    <= idx_next;
        out_reg    <= out_next;
        ovf_reg    <= ovf_next;
        prev_reg   <= prev_next;
        lstop_reg  <= lstop_next;
        lstart_reg <= lstart_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg    <= s_operation;
            start_reg <= s_start_time;
            stop_reg  <= s_stop_time;
            value_reg <= s_region_value[15] ? NO_DEST_VALUE : s_region_value;
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_found_value      = found_reg;
    assign m_breakpoint_count = count_reg;
    assign m_status           = status_reg;

endmodule

/* src/interval_value_map_unit.sv */
// Top level of the interval value map: sequencer and breakpoint memory.
//
//  channel | direction | ports
//  s_      | in        | s_valid, s_ready, s_operation, s_start_time, s_stop_time,
//          |           | s_region_value
//  m_      | out       | m_valid, m_ready, m_found_value, m_breakpoint_count, m_status
//
// Each word runs a scan of the stored breakpoints in the table memory.
// Reset is synchronous and active low; it empties the table at once.
// The block takes one word at a time and holds its result until m_ready.
`timescale 1ns / 1ps

module interval_value_map_unit import ivm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic signed [63:0] s_start_time,
    input  logic signed [63:0] s_stop_time,
    input  logic signed [15:0] s_region_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_found_value,
    output logic [CNT_W-1:0]   m_breakpoint_count,
    output logic [1:0]         m_status
);

    localparam int IDX_W = $clog2(CAPACITY);

    mem_ctrl_t          mem_ctrl;
    logic [IDX_W:0]     rd_addr, wr_addr;
    logic signed [63:0] wr_time, rd_time;
    logic signed [15:0] wr_value, rd_value;

    ivm_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_start_time       (s_start_time),
        .s_stop_time        (s_stop_time),
        .s_region_value     (s_region_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found_value      (m_found_value),
        .m_breakpoint_count (m_breakpoint_count),
        .m_status           (m_status),
        .mem_ctrl           (mem_ctrl),
        .rd_addr            (rd_addr),
        .wr_addr            (wr_addr),
        .wr_time            (wr_time),
        .wr_value           (wr_value),
        .rd_time            (rd_time),
        .rd_value           (rd_value)
    );

    ivm_mem #(
        .ADDR_W (IDX_W + 1)
    ) u_mem (
        .aclk     (aclk),
        .ctrl     (mem_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_time  (wr_time),
        .wr_value (wr_value),
        .rd_time  (rd_time),
        .rd_value (rd_value)
    );

endmodule

/* src/ivm_checker.sv */
// Port-level checker for the interval value map, bound to the top level.
`timescale 1ns / 1ps

module ivm_port_props import ivm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CNT_W-1:0]   m_breakpoint_count,
    input logic [1:0]         m_status
);

    // No result is shown in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The block never takes a word while a result is pending.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result waits");

    // Status is one of the defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_ORDER ||
                     m_status == STATUS_FULL))
        else $error("undefined status code");

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_breakpoint_count <= CNT_W'(CAPACITY)))
        else $error("breakpoint count beyond capacity");

    // A stalled result keeps its status.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind interval_value_map_unit ivm_port_props #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_ivm_port_props (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_breakpoint_count (m_breakpoint_count),
    .m_status           (m_status)
);
